/* design/dlm_pkg.sv */
// Shared widths, register indexes and level codes of the dust level monitor.
package dlm_pkg;

   localparam int COUNT_W    = 8;
   localparam int BASELINE_W = 10;
   localparam int GAIN_W     = 16;
   localparam int ALPHA_REG_W = 9;
   localparam int LIMIT_W    = 14;
   localparam int DENS_W     = 14;
   localparam int LEVEL_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_COUNT    = 3'd0,
      CSR_BASELINE_COUNTS = 3'd1,
      CSR_GAIN_Q8         = 3'd2,
      CSR_ALPHA_Q8        = 3'd3,
      CSR_LOW_LIMIT       = 3'd4,
      CSR_MODERATE_LIMIT  = 3'd5,
      CSR_FAULT_SET       = 3'd6,
      CSR_FAULT_CLEAR     = 3'd7
   } csr_idx_type;

   typedef enum logic [LEVEL_W-1:0] {
      LEVEL_CLEAR    = 2'd0,
      LEVEL_LOW      = 2'd1,
      LEVEL_MODERATE = 2'd2,
      LEVEL_HIGH     = 2'd3
   } level_type;

endpackage

/* design/dlm_req_if.sv */
// Sample channel: valid, ready and one raw converter reading.
interface dlm_req_if #(
   parameter int ADC_BITS = 10
) ();
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

/* design/dlm_rsp_if.sv */
// Result channel: valid, ready and one filtered density report.
interface dlm_rsp_if
   import dlm_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [DENS_W-1:0]  density;
   logic [LEVEL_W-1:0] level;
   logic               wiring_fault;
   logic               fault_new;

   modport source (output valid, output density, output level, output wiring_fault,
                   output fault_new, input ready);
   modport sink   (input valid, input density, input level, input wiring_fault,
                   input fault_new, output ready);
endinterface

/* design/dust_level_monitor_top.sv */
// Dust level monitor: windowed sample sum, bit-serial density math, filter and fault flag.
// A sample that does not close a window is taken in ST_IDLE and ready stays high.
// A window-closing sample passes through ST_BASE, ST_MUL, ST_DIV, ST_FSET, ST_FILT, ST_FIN and ST_DONE
// (ready low until ST_DONE hands its result on): a 1-bit shift-add multiply, a restoring divide
// by the window length and a 1-bit filter multiply share one sequencer, one item at a time.
// Synchronous active-high reset restores register defaults, clears the sum and the filter.
module dust_level_monitor_top
   import dlm_pkg::*;
#(
   parameter int ADC_BITS  = 10,
   parameter int FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   dlm_req_if.sink               req_ch,
   dlm_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W   = ADC_BITS + COUNT_W;
   localparam int PROD_W  = SUM_W + GAIN_W;
   localparam int FILT_W  = DENS_W + FRAC_BITS;
   localparam int ALPHA_W = (FRAC_BITS + 1 > ALPHA_REG_W) ? FRAC_BITS + 1 : ALPHA_REG_W;
   localparam int MACC_W  = FILT_W + ALPHA_W;
   localparam int BASE_W  = BASELINE_W + COUNT_W;
   localparam int CMP_W   = (SUM_W > BASE_W) ? SUM_W : BASE_W;
   localparam int CNT_W   = $clog2(PROD_W + 1);
   localparam logic [ALPHA_W-1:0] ONE_Q = ALPHA_W'(64'd1 << FRAC_BITS);
   localparam logic [63:0] HALF_Q = 64'd1 << (FRAC_BITS - 1);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_BASE = 8'b0000_0010,
      ST_MUL  = 8'b0000_0100,
      ST_DIV  = 8'b0000_1000,
      ST_FSET = 8'b0001_0000,
      ST_FILT = 8'b0010_0000,
      ST_FIN  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [BASELINE_W-1:0] baseline_ff, baseline_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [ALPHA_REG_W-1:0] alpha_ff, alpha_in;
   logic [LIMIT_W-1:0]    low_ff, low_in, mod_ff, mod_in;
   logic [LIMIT_W-1:0]    fset_ff, fset_in, fclr_ff, fclr_in;

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] idx_ff, idx_in, n_ff, n_in;
   logic [FILT_W-1:0]  filt_ff, filt_in;
   logic               fault_ff, fault_in;

   logic [PROD_W-1:0]  acc_ff, acc_in, mcand_ff, mcand_in;
   logic [GAIN_W-1:0]  mplier_ff, mplier_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MACC_W-1:0]  macc_ff, macc_in, fx_ff, fx_in, dx_ff, dx_in;
   logic [ALPHA_W-1:0] a_ff, a_in, b_ff, b_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DENS_W-1:0]  density_ff, density_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               wfault_ff, wfault_in, fnew_ff, fnew_in;

   // datapath temporaries
   logic [COUNT_W-1:0] n_next, count_eff;
   logic [BASE_W-1:0]  base;
   logic [CMP_W-1:0]   sum_x, base_x, diff_x;
   logic [COUNT_W:0]   rem_sh;
   logic               q_bit;
   logic [FILT_W-1:0]  dens_raw;
   logic [ALPHA_W-1:0] alpha_eff;
   logic [MACC_W-1:0]  macc_rnd;
   logic [FILT_W:0]    dsum;
   logic [DENS_W:0]    dq;
   logic [DENS_W-1:0]  dens_out;
   logic               out_free;

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.density      = density_ff;
   assign rsp_ch.level        = level_ff;
   assign rsp_ch.wiring_fault = wfault_ff;
   assign rsp_ch.fault_new    = fnew_ff;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign count_eff = (count_ff == '0) ? COUNT_W'(1) : count_ff;
   assign n_next    = idx_ff + COUNT_W'(1);
   assign base      = BASE_W'(baseline_ff) * BASE_W'(n_ff);
   assign sum_x     = CMP_W'(sum_ff);
   assign base_x    = CMP_W'(base);
   assign diff_x    = (sum_x > base_x) ? sum_x - base_x : '0;
   assign rem_sh    = {rem_ff, acc_ff[PROD_W-1]};
   assign q_bit     = (rem_sh >= {1'b0, n_ff});
   assign dens_raw  = (|acc_ff[PROD_W-1:FILT_W]) ? '1 : acc_ff[FILT_W-1:0];
   assign alpha_eff = (ALPHA_W'(alpha_ff) > ONE_Q) ? ONE_Q : ALPHA_W'(alpha_ff);
   assign macc_rnd  = macc_ff + MACC_W'(HALF_Q);
   assign dsum      = {1'b0, filt_ff} + (FILT_W + 1)'(HALF_Q);
   assign dq        = dsum[FILT_W:FRAC_BITS];
   assign dens_out  = dq[DENS_W] ? '1 : dq[DENS_W-1:0];

   always_comb begin
      count_in    = count_ff;
      baseline_in = baseline_ff;
      gain_in     = gain_ff;
      alpha_in    = alpha_ff;
      low_in      = low_ff;
      mod_in      = mod_ff;
      fset_in     = fset_ff;
      fclr_in     = fclr_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_SAMPLE_COUNT:    count_in    = csr_wdata[COUNT_W-1:0];
            CSR_BASELINE_COUNTS: baseline_in = csr_wdata[BASELINE_W-1:0];
            CSR_GAIN_Q8:         gain_in     = csr_wdata[GAIN_W-1:0];
            CSR_ALPHA_Q8:        alpha_in    = csr_wdata[ALPHA_REG_W-1:0];
            CSR_LOW_LIMIT:       low_in      = csr_wdata[LIMIT_W-1:0];
            CSR_MODERATE_LIMIT:  mod_in      = csr_wdata[LIMIT_W-1:0];
            CSR_FAULT_SET:       fset_in     = csr_wdata[LIMIT_W-1:0];
            CSR_FAULT_CLEAR:     fclr_in     = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      filt_in      = filt_ff;
      fault_in     = fault_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      macc_in      = macc_ff;
      fx_in        = fx_ff;
      dx_in        = dx_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      density_in   = density_ff;
      level_in     = level_ff;
      wfault_in    = wfault_ff;
      fnew_in      = fnew_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               sum_in = sum_ff + SUM_W'(req_ch.adc_sample);
               if (n_next < count_eff) begin
                  idx_in = n_next;
               end else begin
                  n_in     = n_next;
                  state_in = ST_BASE;
               end
            end
         end
         ST_BASE: begin
            mcand_in  = PROD_W'(diff_x);
            mplier_in = gain_ff;
            acc_in    = '0;
            cnt_in    = '0;
            sum_in    = '0;
            idx_in    = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            // shift-add, one gain bit per cycle
            if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(GAIN_W - 1)) begin
               cnt_in   = '0;
               rem_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring divide; quotient bits shift into the dividend register
            rem_in = q_bit ? COUNT_W'(rem_sh - {1'b0, n_ff}) : rem_sh[COUNT_W-1:0];
            acc_in = {acc_ff[PROD_W-2:0], q_bit};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(PROD_W - 1)) state_in = ST_FSET;
         end
         ST_FSET: begin
            fx_in    = MACC_W'(filt_ff);
            dx_in    = MACC_W'(dens_raw);
            a_in     = alpha_eff;
            b_in     = ONE_Q - alpha_eff;
            macc_in  = '0;
            cnt_in   = '0;
            state_in = ST_FILT;
         end
         ST_FILT: begin
            macc_in = macc_ff + (a_ff[0] ? fx_ff : '0) + (b_ff[0] ? dx_ff : '0);
            fx_in   = {fx_ff[MACC_W-2:0], 1'b0};
            dx_in   = {dx_ff[MACC_W-2:0], 1'b0};
            a_in    = a_ff >> 1;
            b_in    = b_ff >> 1;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ALPHA_W - 1)) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (|macc_rnd[MACC_W-1:FRAC_BITS+FILT_W]) filt_in = '1;
            else filt_in = macc_rnd[FRAC_BITS +: FILT_W];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               density_in   = dens_out;
               if (dens_out == '0)            level_in = LEVEL_CLEAR;
               else if (dens_out < low_ff)    level_in = LEVEL_LOW;
               else if (dens_out < mod_ff)    level_in = LEVEL_MODERATE;
               else                           level_in = LEVEL_HIGH;
               fnew_in = 1'b0;
               if (dens_out > fset_ff) begin
                  fnew_in  = !fault_ff;
                  fault_in = 1'b1;
               end else if (fault_ff && dens_out <= fclr_ff) begin
                  fault_in = 1'b0;
               end
               wfault_in = (dens_out > fset_ff) ? 1'b1
                         : ((fault_ff && dens_out <= fclr_ff) ? 1'b0 : fault_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_W'(50);
         baseline_ff  <= BASELINE_W'(143);
         gain_ff      <= GAIN_W'(2502);
         alpha_ff     <= ALPHA_REG_W'(218);
         low_ff       <= LIMIT_W'(50);
         mod_ff       <= LIMIT_W'(150);
         fset_ff      <= LIMIT_W'(800);
         fclr_ff      <= LIMIT_W'(500);
         sum_ff       <= '0;
         idx_ff       <= '0;
         filt_ff      <= '0;
         fault_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         baseline_ff  <= baseline_in;
         gain_ff      <= gain_in;
         alpha_ff     <= alpha_in;
         low_ff       <= low_in;
         mod_ff       <= mod_in;
         fset_ff      <= fset_in;
         fclr_ff      <= fclr_in;
         sum_ff       <= sum_in;
         idx_ff       <= idx_in;
         filt_ff      <= filt_in;
         fault_ff     <= fault_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      rem_ff     <= rem_in;
      macc_ff    <= macc_in;
      fx_ff      <= fx_in;
      dx_ff      <= dx_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      density_ff <= density_in;
      level_ff   <= level_in;
      wfault_ff  <= wfault_in;
      fnew_ff    <= fnew_in;
   end

endmodule

/* design/dlm_checker.sv */
// Port-level checks of the dust level monitor and their bind to the top level.
module dlm_checker
   import dlm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DENS_W-1:0]  density,
   input logic [LEVEL_W-1:0] level,
   input logic               wiring_fault,
   input logic               fault_new
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(density) && $stable(level)
         && $stable(wiring_fault) && $stable(fault_new))
      else $error("stalled result changed");

   a_clear_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((density == '0) == (level == LEVEL_CLEAR)))
      else $error("level clear does not match zero density");

   a_new_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fault_new |-> wiring_fault)
      else $error("new fault without fault flag");

   // a result only appears after a busy stretch
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while sample channel was open");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind dust_level_monitor_top dlm_checker u_dlm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .density      (rsp_ch.density),
   .level        (rsp_ch.level),
   .wiring_fault (rsp_ch.wiring_fault),
   .fault_new    (rsp_ch.fault_new)
);

/* bench/tb_dust_level_monitor_top.sv */
// Testbench for the dust level monitor: directed table, then random windows vs. a predictor.
module tb_dust_level_monitor_top;
   import dlm_pkg::*;

   localparam int ADC_BITS = 10;
   localparam int FRAC_BITS = 8;
   localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
   localparam logic [63:0] DENS_MAX = (64'd1 << DENS_W) - 64'd1;
   localparam logic [63:0] FILT_MAX = ((64'd1 << DENS_W) << FRAC_BITS) - 64'd1;
   localparam int SETTLE_CYCLES = 80;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 1530;

   typedef struct packed {
      logic [DENS_W-1:0] density;
      level_type         level;
      logic              wiring_fault;
      logic              fault_new;
   } dens_report_type;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      csr_idx_type           index;
      logic [CSR_DATA_W-1:0] value;
      bit                    typed;
      dens_report_type       want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dlm_req_if #(.ADC_BITS(ADC_BITS)) req_ch ();
   dlm_rsp_if rsp_ch ();

   dust_level_monitor_top #(
      .ADC_BITS(ADC_BITS),
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // shadow registers and window state of the predictor
   logic [COUNT_W-1:0]     cfg_count;
   logic [BASELINE_W-1:0]  cfg_base;
   logic [GAIN_W-1:0]      cfg_gain;
   logic [ALPHA_REG_W-1:0] cfg_alpha;
   logic [LIMIT_W-1:0]     cfg_low, cfg_mod, cfg_fset, cfg_fclr;
   logic [17:0]            win_sum;
   logic [7:0]             win_fill;
   logic [21:0]            filt_q8;
   logic                   fault_on;

   dens_report_type pending_reports[$];
   stim_row_type    plan[$];
   int              error_count = 0;
   int              quiet_cycles = 0;
   bit              steady = 1'b0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic flag_error(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Add one sample to the window; on window end compute the filtered report.
   function automatic bit advance_window(input logic [ADC_BITS-1:0] reading,
                                         output dens_report_type rpt);
      logic [63:0] span, n, base, excess, raw, wt, nxt, rounded;
      rpt = '0;
      span = (cfg_count == 0) ? 64'd1 : 64'(cfg_count);
      win_sum = win_sum + 18'(reading);
      n = 64'(win_fill) + 64'd1;
      if (n < span) begin
         win_fill = n[7:0];
         return 1'b0;
      end
      base = 64'(cfg_base) * n;
      excess = (64'(win_sum) > base) ? 64'(win_sum) - base : 64'd0;
      raw = excess * 64'(cfg_gain) / n;
      if (raw > FILT_MAX) raw = FILT_MAX;
      win_sum = '0;
      win_fill = '0;
      wt = (64'(cfg_alpha) > ONE_Q) ? ONE_Q : 64'(cfg_alpha);
      nxt = (wt * 64'(filt_q8) + (ONE_Q - wt) * raw + (ONE_Q >> 1)) >> FRAC_BITS;
      if (nxt > FILT_MAX) nxt = FILT_MAX;
      filt_q8 = nxt[21:0];
      rounded = (64'(filt_q8) + (ONE_Q >> 1)) >> FRAC_BITS;
      if (rounded > DENS_MAX) rounded = DENS_MAX;
      if (rounded == 0) begin
         rpt.level = LEVEL_CLEAR;
      end else if (rounded < 64'(cfg_low)) begin
         rpt.level = LEVEL_LOW;
      end else if (rounded < 64'(cfg_mod)) begin
         rpt.level = LEVEL_MODERATE;
      end else begin
         rpt.level = LEVEL_HIGH;
      end
      if (rounded > 64'(cfg_fset)) begin
         rpt.fault_new = !fault_on;
         fault_on = 1'b1;
      end else if (fault_on && rounded <= 64'(cfg_fclr)) begin
         fault_on = 1'b0;
      end
      rpt.wiring_fault = fault_on;
      rpt.density = rounded[DENS_W-1:0];
      return 1'b1;
   endfunction

   function automatic void add_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      stim_row_type row;
      row.kind = ROW_CSR;
      row.index = idx;
      row.value = val;
      row.typed = 1'b0;
      row.want = '0;
      plan.push_back(row);
   endfunction

   function automatic void add_sample(input logic [ADC_BITS-1:0] reading);
      stim_row_type row;
      row.kind = ROW_SAMPLE;
      row.index = CSR_SAMPLE_COUNT;
      row.value = CSR_DATA_W'(reading);
      row.typed = 1'b0;
      row.want = '0;
      plan.push_back(row);
   endfunction

   function automatic void add_typed(input logic [ADC_BITS-1:0] reading,
                                     input logic [DENS_W-1:0] dens, input level_type lvl,
                                     input logic fault, input logic fresh);
      stim_row_type row;
      row.kind = ROW_SAMPLE;
      row.index = CSR_SAMPLE_COUNT;
      row.value = CSR_DATA_W'(reading);
      row.typed = 1'b1;
      row.want.density = dens;
      row.want.level = lvl;
      row.want.wiring_fault = fault;
      row.want.fault_new = fresh;
      plan.push_back(row);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_limit();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return 16'd16383;
      if (roll < 28) return CSR_DATA_W'($urandom_range(0, 16'hFFFF));
      return CSR_DATA_W'($urandom_range(0, 2000));
   endfunction

   // Hold the sender until every pending report is in, then let the block go quiet.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SAMPLE_COUNT:    cfg_count = val[COUNT_W-1:0];
         CSR_BASELINE_COUNTS: cfg_base = val[BASELINE_W-1:0];
         CSR_GAIN_Q8:         cfg_gain = val[GAIN_W-1:0];
         CSR_ALPHA_Q8:        cfg_alpha = val[ALPHA_REG_W-1:0];
         CSR_LOW_LIMIT:       cfg_low = val[LIMIT_W-1:0];
         CSR_MODERATE_LIMIT:  cfg_mod = val[LIMIT_W-1:0];
         CSR_FAULT_SET:       cfg_fset = val[LIMIT_W-1:0];
         CSR_FAULT_CLEAR:     cfg_fclr = val[LIMIT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [ADC_BITS-1:0] reading, input bit typed,
                              input dens_report_type want);
      dens_report_type rpt;
      while (!steady && $urandom_range(0, 99) < 36) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.adc_sample <= reading;
      do @(posedge clock); while (!req_ch.ready);
      if (advance_window(reading, rpt)) pending_reports.push_back(typed ? want : rpt);
   endtask

   always @(posedge clock) begin
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 36);
   end

   always @(posedge clock) begin : check_reports
      dens_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_reports.size() == 0) begin
            flag_error($sformatf("unexpected report, density %0d", rsp_ch.density));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_ch.density !== want.density)
               flag_error($sformatf("density %0d, want %0d", rsp_ch.density, want.density));
            if (rsp_ch.level !== want.level)
               flag_error($sformatf("level %0d, want %0d", rsp_ch.level, want.level));
            if (rsp_ch.wiring_fault !== want.wiring_fault)
               flag_error($sformatf("wiring_fault %0b, want %0b",
                                    rsp_ch.wiring_fault, want.wiring_fault));
            if (rsp_ch.fault_new !== want.fault_new)
               flag_error($sformatf("fault_new %0b, want %0b",
                                    rsp_ch.fault_new, want.fault_new));
         end
      end
   end

   // end the run when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int sent, phase, run_len, roll, center, val;
      logic [CSR_DATA_W-1:0] word;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_SAMPLE_COUNT;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.adc_sample <= '0;
      cfg_count = 8'd50;
      cfg_base = 10'd143;
      cfg_gain = 16'd2502;
      cfg_alpha = 9'd218;
      cfg_low = 14'd50;
      cfg_mod = 14'd150;
      cfg_fset = 14'd800;
      cfg_fclr = 14'd500;
      win_sum = '0;
      win_fill = '0;
      filt_q8 = '0;
      fault_on = 1'b0;

      // one-sample windows at unity gain and no filtering: density equals the reading
      add_csr(CSR_SAMPLE_COUNT, 16'd1);
      add_typed(10'd0, 14'd0, LEVEL_CLEAR, 1'b0, 1'b0);
      add_csr(CSR_ALPHA_Q8, 16'd0);
      add_csr(CSR_BASELINE_COUNTS, 16'd0);
      add_csr(CSR_GAIN_Q8, 16'd256);
      add_typed(10'd1023, 14'd1023, LEVEL_HIGH, 1'b1, 1'b1);
      add_typed(10'd600, 14'd600, LEVEL_HIGH, 1'b1, 1'b0);
      add_typed(10'd500, 14'd500, LEVEL_HIGH, 1'b0, 1'b0);
      add_typed(10'd1, 14'd1, LEVEL_LOW, 1'b0, 1'b0);
      add_typed(10'd100, 14'd100, LEVEL_MODERATE, 1'b0, 1'b0);
      add_typed(10'd150, 14'd150, LEVEL_HIGH, 1'b0, 1'b0);
      // saturate the raw density, then hold it with full weight on the old value
      add_csr(CSR_GAIN_Q8, 16'hFFFF);
      add_typed(10'd1023, 14'd16383, LEVEL_HIGH, 1'b1, 1'b1);
      add_csr(CSR_ALPHA_Q8, 16'd256);
      add_typed(10'd0, 14'd16383, LEVEL_HIGH, 1'b1, 1'b0);
      add_csr(CSR_ALPHA_Q8, 16'hFFFF);
      add_typed(10'd0, 14'd16383, LEVEL_HIGH, 1'b1, 1'b0);
      // limits at their extremes: full scale clears the fault
      add_csr(CSR_ALPHA_Q8, 16'd0);
      add_csr(CSR_FAULT_SET, 16'd16383);
      add_csr(CSR_FAULT_CLEAR, 16'hFFFF);
      add_csr(CSR_LOW_LIMIT, 16'd0);
      add_csr(CSR_MODERATE_LIMIT, 16'd16383);
      add_typed(10'd1023, 14'd16383, LEVEL_HIGH, 1'b0, 1'b0);
      add_typed(10'd0, 14'd0, LEVEL_CLEAR, 1'b0, 1'b0);
      add_csr(CSR_FAULT_SET, 16'd0);
      add_csr(CSR_FAULT_CLEAR, 16'd0);
      add_csr(CSR_GAIN_Q8, 16'd2502);
      add_csr(CSR_BASELINE_COUNTS, 16'd143);
      add_csr(CSR_ALPHA_Q8, 16'd218);
      add_sample(10'd200);
      // a window length of zero behaves as one
      add_csr(CSR_SAMPLE_COUNT, 16'h0100);
      add_sample(10'd1023);
      add_sample(10'd143);
      add_csr(CSR_BASELINE_COUNTS, 16'hFFFF);
      add_sample(10'd1023);
      // shorten an open window: the next reading closes it
      add_csr(CSR_BASELINE_COUNTS, 16'd143);
      add_csr(CSR_LOW_LIMIT, 16'd50);
      add_csr(CSR_MODERATE_LIMIT, 16'd150);
      add_csr(CSR_FAULT_SET, 16'd800);
      add_csr(CSR_FAULT_CLEAR, 16'd500);
      add_csr(CSR_SAMPLE_COUNT, 16'd4);
      add_sample(10'd700);
      add_sample(10'd300);
      add_csr(CSR_SAMPLE_COUNT, 16'd2);
      add_sample(10'd900);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CSR) begin
            settle();
            write_csr(plan[r].index, plan[r].value);
         end else begin
            send_sample(plan[r].value[ADC_BITS-1:0], plan[r].typed, plan[r].want);
         end
      end

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         settle();
         steady = (phase == 4 || phase == 5);

         roll = $urandom_range(0, 99);
         if (phase == 2) word = 16'd255;
         else if (roll < 8) word = CSR_DATA_W'($urandom_range(0, 16'hFFFF));
         else if (roll < 20) word = CSR_DATA_W'($urandom_range(7, 40));
         else word = CSR_DATA_W'($urandom_range(0, 6));
         write_csr(CSR_SAMPLE_COUNT, word);

         roll = $urandom_range(0, 99);
         if (roll < 15) word = '0;
         else if (roll < 25) word = 16'd1023;
         else if (roll < 35) word = CSR_DATA_W'($urandom_range(0, 16'hFFFF));
         else word = CSR_DATA_W'($urandom_range(100, 200));
         write_csr(CSR_BASELINE_COUNTS, word);
         center = int'(word[BASELINE_W-1:0]);

         roll = $urandom_range(0, 99);
         if (roll < 10) word = '0;
         else if (roll < 20) word = 16'hFFFF;
         else if (roll < 35) word = CSR_DATA_W'($urandom_range(0, 16'hFFFF));
         else word = CSR_DATA_W'($urandom_range(0, 4095));
         write_csr(CSR_GAIN_Q8, word);

         roll = $urandom_range(0, 99);
         if (roll < 10) word = '0;
         else if (roll < 20) word = 16'd256;
         else if (roll < 30) word = CSR_DATA_W'($urandom_range(257, 511));
         else if (roll < 35) word = CSR_DATA_W'($urandom_range(0, 16'hFFFF));
         else word = CSR_DATA_W'($urandom_range(0, 255));
         write_csr(CSR_ALPHA_Q8, word);

         write_csr(CSR_LOW_LIMIT, pick_limit());
         write_csr(CSR_MODERATE_LIMIT, pick_limit());
         write_csr(CSR_FAULT_SET, pick_limit());
         write_csr(CSR_FAULT_CLEAR, pick_limit());

         run_len = (phase == 2) ? 300 : $urandom_range(40, 90);
         repeat (run_len) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               val = $urandom_range(0, 1) ? 1023 : 0;
            end else if (roll < 25) begin
               val = $urandom_range(0, 1023);
            end else begin
               val = center + $urandom_range(0, 160) - 80;
               if (val < 0) val = 0;
               if (val > 1023) val = 1023;
            end
            send_sample(ADC_BITS'(val), 1'b0, '0);
            sent++;
         end
         phase++;
      end

      steady = 1'b0;
      settle();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
design/dlm_pkg.sv
design/dlm_req_if.sv
design/dlm_rsp_if.sv
design/dust_level_monitor_top.sv
design/dlm_checker.sv
bench/tb_dust_level_monitor_top.sv
